>>> rtl/core/three_wire_serial_master_assert.svh
// Assertion macros used by the checker file of the three-wire serial master.
`ifndef THREE_WIRE_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_SERIAL_MASTER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define TWS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// A condition that forces a consequence at the next clock edge.
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/tws_pkg.sv
// Package with the types and constants of the three-wire serial master.
package tws_pkg;

	localparam int FIELD_BITS = 8;
	localparam int CNT_W = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [FIELD_BITS-1:0] CMD_WRITE_MASK = 8'hFE;
	localparam logic [FIELD_BITS-1:0] CMD_READ_BIT = 8'h01;
	localparam logic [CNT_W-1:0] CMD_BITS = CNT_W'(FIELD_BITS);
	localparam logic [CNT_W-1:0] TOTAL_BITS = CNT_W'(2 * FIELD_BITS);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		logic start_req;
		op_t op;
		logic [FIELD_BITS-1:0] command_byte;
		logic [FIELD_BITS-1:0] write_data;
		logic line_in;
	} tws_item_t;

	typedef struct packed {
		logic chip_enable;
		logic serial_clock;
		logic line_out;
		logic line_drive;
		logic busy_res;
		logic done_res;
		logic [FIELD_BITS-1:0] read_result;
	} tws_result_t;

endpackage

>>> rtl/core/tws_front.sv
// Front part: accepts items, forces the direction bit and queues them.
module tws_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input logic start_req,
	input logic op,
	input logic [tws_pkg::FIELD_BITS-1:0] command_byte,
	input logic [tws_pkg::FIELD_BITS-1:0] write_data,
	input logic line_in,
	output logic q_valid,
	input logic q_pop,
	output tws_pkg::tws_item_t q_item
);

	tws_pkg::tws_item_t slot_q [tws_pkg::QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	tws_pkg::tws_item_t cls_item;
	logic push;
	logic pop;

	always_comb begin
		cls_item.start_req = start_req;
		cls_item.op = tws_pkg::op_t'(op);
		cls_item.write_data = write_data;
		cls_item.line_in = line_in;
		if (tws_pkg::op_t'(op) == tws_pkg::OP_READ) begin
			cls_item.command_byte = command_byte | tws_pkg::CMD_READ_BIT;
		end else begin
			cls_item.command_byte = command_byte & tws_pkg::CMD_WRITE_MASK;
		end
	end

	assign item_ready = (count_q != 2'(tws_pkg::QUEUE_DEPTH));
	assign push = item_valid && item_ready;
	assign q_valid = (count_q != 2'd0);
	assign pop = q_pop && q_valid;
	assign q_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> rtl/core/tws_back.sv
// Back part: runs one half-bit tick per queued item and holds the result.
module tws_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input tws_pkg::tws_item_t q_item,
	output logic res_valid,
	input logic res_ready,
	output tws_pkg::tws_result_t res
);

	logic active_q;
	logic reading_q;
	logic [tws_pkg::CNT_W-1:0] cnt_q;
	logic clock_high_q;
	logic [tws_pkg::FIELD_BITS-1:0] cmd_sh_q;
	logic [tws_pkg::FIELD_BITS-1:0] data_sh_q;
	logic [tws_pkg::FIELD_BITS-1:0] hold_q;
	logic res_valid_q;
	tws_pkg::tws_result_t res_q;

	logic active_n;
	logic reading_n;
	logic [tws_pkg::CNT_W-1:0] cnt_n;
	logic clock_high_n;
	logic [tws_pkg::FIELD_BITS-1:0] cmd_sh_n;
	logic [tws_pkg::FIELD_BITS-1:0] data_sh_n;
	logic [tws_pkg::FIELD_BITS-1:0] hold_n;
	tws_pkg::tws_result_t res_n;

	assign q_pop = q_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		active_n = active_q;
		reading_n = reading_q;
		cnt_n = cnt_q;
		clock_high_n = clock_high_q;
		cmd_sh_n = cmd_sh_q;
		data_sh_n = data_sh_q;
		hold_n = hold_q;
		res_n.done_res = 1'b0;
		if (!active_q) begin
			if (q_item.start_req) begin
				active_n = 1'b1;
				reading_n = (q_item.op == tws_pkg::OP_READ);
				cnt_n = '0;
				clock_high_n = 1'b0;
				cmd_sh_n = q_item.command_byte;
				data_sh_n = (q_item.op == tws_pkg::OP_READ) ? '0 : q_item.write_data;
			end
		end else if (!clock_high_q) begin
			if (reading_q && cnt_q >= tws_pkg::CMD_BITS) begin
				data_sh_n = {q_item.line_in, data_sh_q[tws_pkg::FIELD_BITS-1:1]};
			end
			clock_high_n = 1'b1;
		end else begin
			clock_high_n = 1'b0;
			if (cnt_q < tws_pkg::CMD_BITS) begin
				cmd_sh_n = cmd_sh_q >> 1;
			end else if (!reading_q) begin
				data_sh_n = data_sh_q >> 1;
			end
			cnt_n = cnt_q + 1'b1;
			if (cnt_n >= tws_pkg::TOTAL_BITS) begin
				active_n = 1'b0;
				res_n.done_res = 1'b1;
				cnt_n = '0;
				if (reading_q) begin
					hold_n = data_sh_n;
				end
			end
		end

		res_n.line_out = 1'b0;
		res_n.line_drive = 1'b0;
		if (active_n) begin
			if (cnt_n < tws_pkg::CMD_BITS) begin
				res_n.line_out = cmd_sh_n[0];
				res_n.line_drive = 1'b1;
			end else if (!reading_n) begin
				res_n.line_out = data_sh_n[0];
				res_n.line_drive = 1'b1;
			end else begin
				res_n.line_out = 1'b1;
			end
		end
		res_n.chip_enable = active_n;
		res_n.busy_res = active_n;
		res_n.serial_clock = active_n && clock_high_n;
		res_n.read_result = hold_n;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			reading_q <= 1'b0;
			cnt_q <= '0;
			clock_high_q <= 1'b0;
			cmd_sh_q <= '0;
			data_sh_q <= '0;
			hold_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= active_n;
				reading_q <= reading_n;
				cnt_q <= cnt_n;
				clock_high_q <= clock_high_n;
				cmd_sh_q <= cmd_sh_n;
				data_sh_q <= data_sh_n;
				hold_q <= hold_n;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/three_wire_serial_master.sv
// Top level of the three-wire serial master: front queue and tick engine.
// Each item is one half-bit tick; one item is taken and one result given per cycle while results are taken.
// An accepted item is stored in the two-entry queue and then registered in the result register.
// The tick engine's state register advances only when an item is popped from the queue.
// A transfer spans 4*FIELD_BITS+1 items, the start item included.
// Reset is asynchronous and clears the queue, the transfer state and the read byte.
module three_wire_serial_master (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input logic start_req,
	input logic op,
	input logic [tws_pkg::FIELD_BITS-1:0] command_byte,
	input logic [tws_pkg::FIELD_BITS-1:0] write_data,
	input logic line_in,
	output logic result_valid,
	input logic result_ready,
	output logic chip_enable,
	output logic serial_clock,
	output logic line_out,
	output logic line_drive,
	output logic busy_res,
	output logic done_res,
	output logic [tws_pkg::FIELD_BITS-1:0] read_result
);

	logic q_valid;
	logic q_pop;
	tws_pkg::tws_item_t q_item;
	tws_pkg::tws_result_t res;

	tws_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.start_req(start_req),
		.op(op),
		.command_byte(command_byte),
		.write_data(write_data),
		.line_in(line_in),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_item(q_item)
	);

	tws_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_item(q_item),
		.res_valid(result_valid),
		.res_ready(result_ready),
		.res(res)
	);

	assign chip_enable = res.chip_enable;
	assign serial_clock = res.serial_clock;
	assign line_out = res.line_out;
	assign line_drive = res.line_drive;
	assign busy_res = res.busy_res;
	assign done_res = res.done_res;
	assign read_result = res.read_result;

endmodule

>>> rtl/core/tws_checker.sv
// Port checker of the three-wire serial master and its bind statement.
`include "three_wire_serial_master_assert.svh"

module tws_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input logic chip_enable,
	input logic serial_clock,
	input logic line_out,
	input logic line_drive,
	input logic busy_res,
	input logic done_res,
	input logic [tws_pkg::FIELD_BITS-1:0] read_result
);

	logic [tws_pkg::FIELD_BITS+5:0] pin_bus;
	logic pins_busy;
	logic res_stall;

	assign pin_bus = {chip_enable, serial_clock, line_out, line_drive, busy_res, done_res,
		read_result};
	assign pins_busy = serial_clock || line_out || line_drive;
	assign res_stall = result_valid && !result_ready;

	`TWS_ASSERT_NEXT(a_result_holds, clk, arst_n, res_stall, result_valid && $stable(pin_bus))
	`TWS_ASSERT_ALWAYS(a_enable_busy, clk, arst_n, !result_valid || chip_enable == busy_res)
	`TWS_ASSERT_ALWAYS(a_done_idle, clk, arst_n, !result_valid || !done_res || !chip_enable)
	`TWS_ASSERT_ALWAYS(a_idle_pins, clk, arst_n, !result_valid || chip_enable || !pins_busy)

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.chip_enable(chip_enable),
	.serial_clock(serial_clock),
	.line_out(line_out),
	.line_drive(line_drive),
	.busy_res(busy_res),
	.done_res(done_res),
	.read_result(read_result)
);
